[sv/chs_pkg.sv]
// shared constants and types of the complex horner series evaluator
`timescale 1ns / 1ps
package chs_pkg;
   localparam int MAX_TERMS_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int TC_WIDTH       = 7;
   localparam int IDX_WIDTH      = 6;
   localparam int CSR_AW         = 2;
   localparam int CSR_DW         = 32;
   localparam logic [CSR_AW-1:0] ADDR_TERM_COUNT = 2'd0;
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;
endpackage

[sv/complex_horner_series_eval_core.sv]
// top level of the complex horner series evaluator
`timescale 1ns / 1ps
// Evaluates q = z*(c0 + c1 z + ... + c(n-1) z^(n-1)) with n = term_count, clamped
// to 2..MAX_TERMS. A load word leaves busy low. An evaluate word holds busy while
// the coefficient ring turns one cell per cycle until c(n-1) reaches the tap, and
// then through the n horner steps, each a registered complex product followed by
// round/add/saturate. The result is shown for exactly one cycle on rsp_strobe and
// cannot be held off; it is lost if not taken. Coefficients never loaded since
// reset read as arbitrary values.
module complex_horner_series_eval_core import chs_pkg::*; #(
   parameter int MAX_TERMS  = MAX_TERMS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [IDX_WIDTH-1:0]         req_coef_index,
   input  logic signed [DATA_WIDTH-1:0] req_coef_re,
   input  logic signed [DATA_WIDTH-1:0] req_coef_im,
   input  logic signed [DATA_WIDTH-1:0] req_point_re,
   input  logic signed [DATA_WIDTH-1:0] req_point_im,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_value_re,
   output logic signed [DATA_WIDTH-1:0] rsp_value_im,
   output logic                         rsp_overflow,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_AW-1:0]            csr_paddr,
   input  logic [CSR_DW-1:0]            csr_pwdata,
   output logic [CSR_DW-1:0]            csr_prdata,
   output logic                         csr_pready
);
   localparam int IW  = $clog2(MAX_TERMS);
   localparam int NW  = (IW + 1 > TC_WIDTH) ? IW + 1 : TC_WIDTH;
   localparam int CIW = (IW > IDX_WIDTH) ? IW : IDX_WIDTH;
   localparam int DW  = DATA_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SKIP = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_ADD  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [TC_WIDTH-1:0]  term_count_ff, term_count_in;
   logic [IW-1:0]        pos_ff, pos_in;
   logic                 last_ff, last_in;
   logic                 ovf_ff, ovf_in;
   logic signed [DW-1:0] z_re_ff, z_im_ff, q_re_ff, q_im_ff;
   logic signed [DW-1:0] z_re_in, z_im_in, q_re_in, q_im_in;
   logic                 strobe_ff, strobe_in;
   logic signed [DW-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 accept, load_fire, shift_en, csr_wr;
   logic [NW-1:0]        tc_w, n_w;
   logic [IW-1:0]        n1;
   logic [CIW-1:0]       idx_w;
   logic signed [DW-1:0] c_re, c_im, r_re, r_im, tap_re, tap_im;
   logic                 mac_ovf;
   logic [2*DW-1:0]      ring [MAX_TERMS];
   logic [2*DW-1:0]      load_data;

   assign accept    = start && !busy;
   assign load_fire = accept && (req_type == REQ_LOAD);
   assign idx_w     = CIW'(req_coef_index);
   assign load_data = {req_coef_re, req_coef_im};
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // coefficient ring: cell k takes cell k-1, tap is the top cell
   for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.load  = load_fire && (idx_w == CIW'(g));
      assign ctrl.shift = shift_en;
      chs_cell #(.DATA_WIDTH(DW)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (load_data),
         .prev_data (ring[(g + MAX_TERMS - 1) % MAX_TERMS]),
         .data      (ring[g])
      );
   end

   assign tap_re = ring[MAX_TERMS-1][2*DW-1:DW];
   assign tap_im = ring[MAX_TERMS-1][DW-1:0];
   assign c_re   = last_ff ? '0 : tap_re;
   assign c_im   = last_ff ? '0 : tap_im;

   chs_mac #(.DATA_WIDTH(DW)) u_mac (
      .clock  (clock),
      .mul_en (state_ff == ST_MUL),
      .z_re   (z_re_ff),
      .z_im   (z_im_ff),
      .q_re   (q_re_ff),
      .q_im   (q_im_ff),
      .c_re   (c_re),
      .c_im   (c_im),
      .r_re   (r_re),
      .r_im   (r_im),
      .ovf    (mac_ovf)
   );

   always_comb begin
      tc_w = NW'(term_count_ff);
      if (tc_w < NW'(2)) begin
         n_w = NW'(2);
      end else if (tc_w > NW'(MAX_TERMS)) begin
         n_w = NW'(MAX_TERMS);
      end else begin
         n_w = tc_w;
      end
      n1 = IW'(n_w - NW'(1));
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      ovf_in     = ovf_ff;
      z_re_in    = z_re_ff;
      z_im_in    = z_im_ff;
      q_re_in    = q_re_ff;
      q_im_in    = q_im_ff;
      strobe_in  = 1'b0;
      out_re_in  = out_re_ff;
      out_im_in  = out_im_ff;
      out_ovf_in = out_ovf_ff;
      shift_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_EVAL)) begin
               z_re_in  = req_point_re;
               z_im_in  = req_point_im;
               pos_in   = IW'(MAX_TERMS - 1);
               last_in  = 1'b0;
               ovf_in   = 1'b0;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            shift_en = 1'b1;
            pos_in   = pos_ff - IW'(1);
            if (pos_ff == n1) begin
               q_re_in  = tap_re;
               q_im_in  = tap_im;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            q_re_in = r_re;
            q_im_in = r_im;
            ovf_in  = ovf_ff | mac_ovf;
            if (last_ff) begin
               strobe_in  = 1'b1;
               out_re_in  = r_re;
               out_im_in  = r_im;
               out_ovf_in = ovf_ff | mac_ovf;
               state_in   = ST_IDLE;
            end else begin
               // c(pos) consumed, ring advances; after c0 comes the final multiply
               shift_en = 1'b1;
               if (pos_ff == '0) begin
                  last_in = 1'b1;
               end else begin
                  pos_in = pos_ff - IW'(1);
               end
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      term_count_in = term_count_ff;
      if (csr_wr && (csr_paddr == ADDR_TERM_COUNT)) begin
         term_count_in = csr_pwdata[TC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         strobe_ff     <= 1'b0;
         term_count_ff <= TC_WIDTH'(2);
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         strobe_ff     <= strobe_in;
         term_count_ff <= term_count_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      ovf_ff     <= ovf_in;
      z_re_ff    <= z_re_in;
      z_im_ff    <= z_im_in;
      q_re_ff    <= q_re_in;
      q_im_ff    <= q_im_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_value_re = out_re_ff;
   assign rsp_value_im = out_im_ff;
   assign rsp_overflow = out_ovf_ff;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (csr_paddr == ADDR_TERM_COUNT) ?
                         CSR_DW'(term_count_ff) : '0;
endmodule

[sv/chs_cell.sv]
// one coefficient cell of the rotating coefficient ring
`timescale 1ns / 1ps
module chs_cell import chs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic [2*DATA_WIDTH-1:0] load_data,
   input  logic [2*DATA_WIDTH-1:0] prev_data,
   output logic [2*DATA_WIDTH-1:0] data
);
   logic [2*DATA_WIDTH-1:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

[sv/chs_mac.sv]
// one horner step: registered complex product, then round, add and saturate
`timescale 1ns / 1ps
module chs_mac import chs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         mul_en,
   input  logic signed [DATA_WIDTH-1:0] z_re,
   input  logic signed [DATA_WIDTH-1:0] z_im,
   input  logic signed [DATA_WIDTH-1:0] q_re,
   input  logic signed [DATA_WIDTH-1:0] q_im,
   input  logic signed [DATA_WIDTH-1:0] c_re,
   input  logic signed [DATA_WIDTH-1:0] c_im,
   output logic signed [DATA_WIDTH-1:0] r_re,
   output logic signed [DATA_WIDTH-1:0] r_im,
   output logic                         ovf
);
   localparam int FRAC = DATA_WIDTH - 9;
   localparam int PW   = 2 * DATA_WIDTH;
   localparam int SW   = PW + 1;
   localparam int TW   = SW - FRAC + 1;
   localparam logic signed [SW-1:0] RND = SW'(1) <<< (FRAC - 1);

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [SW-1:0] s_re, s_im, h_re, h_im;
   logic signed [TW-1:0] t_re, t_im;
   logic                 ov_re, ov_im;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_rr_ff <= PW'(z_re) * PW'(q_re);
         p_ii_ff <= PW'(z_im) * PW'(q_im);
         p_ri_ff <= PW'(z_re) * PW'(q_im);
         p_ir_ff <= PW'(z_im) * PW'(q_re);
      end
   end

   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [TW-1:0] t,
                                                       output logic o);
      logic fits;
      fits = (t[TW-1:DATA_WIDTH-1] == '0) || (t[TW-1:DATA_WIDTH-1] == '1);
      o = !fits;
      if (fits) begin
         sat = t[DATA_WIDTH-1:0];
      end else if (t[TW-1]) begin
         sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   endfunction

   always_comb begin
      s_re = SW'(p_rr_ff) - SW'(p_ii_ff) + RND;
      s_im = SW'(p_ri_ff) + SW'(p_ir_ff) + RND;
      h_re = s_re >>> FRAC;
      h_im = s_im >>> FRAC;
      // shifted sum fits in TW-1 bits, so truncation keeps the value
      t_re = TW'(h_re) + TW'(c_re);
      t_im = TW'(h_im) + TW'(c_im);
      r_re = sat(t_re, ov_re);
      r_im = sat(t_im, ov_im);
      ovf  = ov_re | ov_im;
   end
endmodule

[sim/tb_complex_horner_series_eval_core.sv]
// self-checking testbench of the complex horner series evaluator
`timescale 1ns / 1ps
module tb_complex_horner_series_eval_core;
   import chs_pkg::*;

   localparam int NTERMS = MAX_TERMS_DEF;
   localparam int DW     = DATA_WIDTH_DEF;
   localparam int FRAC   = DW - 9;
   localparam int XW     = DW * 2 + 4;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [DW-1:0] value_re;
      logic signed [DW-1:0] value_im;
      logic                 overflow;
   } series_value_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = REQ_LOAD;
   logic [IDX_WIDTH-1:0] req_coef_index = '0;
   logic signed [DW-1:0] req_coef_re = '0, req_coef_im = '0;
   logic signed [DW-1:0] req_point_re = '0, req_point_im = '0;
   logic rsp_strobe;
   logic signed [DW-1:0] rsp_value_re, rsp_value_im;
   logic rsp_overflow;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   complex_horner_series_eval_core i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow state of the block
   logic signed [DW-1:0] coef_re_mem [NTERMS];
   logic signed [DW-1:0] coef_im_mem [NTERMS];
   logic [TC_WIDTH-1:0]  term_count_q = 7'd2;
   series_value_type     pending_values [$];
   int errors = 0, words_sent = 0, evals_sent = 0, values_seen = 0, ovf_seen = 0;
   int idle_pct = 0;
   int stall_cnt = 0;

   // one rounded, coefficient-added, saturated part of a horner step
   function automatic logic signed [DW-1:0] step_part(
      input logic signed [DW-1:0] a, b, c, d, cf, input logic negate, inout logic ovf);
      logic signed [XW-1:0] pa, pb, s;
      pa = XW'(a) * XW'(b);
      pb = XW'(c) * XW'(d);
      s = negate ? pa - pb : pa + pb;
      s = s + (68'sd1 <<< (FRAC - 1));
      s = s >>> FRAC;
      s = s + XW'(cf);
      if (s > 68'sh7FFF_FFFF) begin
         ovf = 1'b1;
         return {1'b0, {(DW-1){1'b1}}};
      end
      if (s < -68'sh8000_0000) begin
         ovf = 1'b1;
         return {1'b1, {(DW-1){1'b0}}};
      end
      return s[DW-1:0];
   endfunction

   function automatic series_value_type eval_series(input logic signed [DW-1:0] zr, zi);
      series_value_type r;
      int n;
      logic signed [DW-1:0] qr, qi, tr;
      logic ovf;
      n = int'(term_count_q);
      if (n < 2) n = 2;
      if (n > NTERMS) n = NTERMS;
      ovf = 1'b0;
      qr = coef_re_mem[n-1];
      qi = coef_im_mem[n-1];
      for (int k = n - 2; k >= -1; k--) begin
         tr = step_part(zr, qr, zi, qi, (k >= 0) ? coef_re_mem[k] : '0, 1'b1, ovf);
         qi = step_part(zr, qi, zi, qr, (k >= 0) ? coef_im_mem[k] : '0, 1'b0, ovf);
         qr = tr;
      end
      r.value_re = qr;
      r.value_im = qi;
      r.overflow = ovf;
      return r;
   endfunction

   // issue one word, hold start until taken, then maybe idle
   task automatic send_word(input logic kind, input logic [IDX_WIDTH-1:0] idx,
                            input logic signed [DW-1:0] cr, ci, zr, zi);
      int gap;
      start          <= 1'b1;
      req_type       <= kind;
      req_coef_index <= idx;
      req_coef_re    <= cr;
      req_coef_im    <= ci;
      req_point_re   <= zr;
      req_point_im   <= zi;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      if (kind == REQ_LOAD) begin
         coef_re_mem[idx] = cr;
         coef_im_mem[idx] = ci;
      end else begin
         evals_sent++;
         pending_values.push_back(eval_series(zr, zi));
      end
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_values.size() > 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_term_count(input logic [TC_WIDTH-1:0] v);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_TERM_COUNT;
      csr_pwdata  <= CSR_DW'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      term_count_q = v;
      @(posedge clock);
   endtask

   function automatic logic signed [DW-1:0] rand_val(input int wide_pct);
      if ($urandom_range(99) < wide_pct) return $signed($urandom());
      return $signed(DW'($urandom_range(0, 1 << (FRAC + 1)))) - (1 <<< FRAC);
   endfunction

   task automatic test_fill_store;
      for (int i = 0; i < NTERMS; i++)
         send_word(REQ_LOAD, IDX_WIDTH'(i), rand_val(10), rand_val(10), $urandom(),
                   $urandom());
   endtask

   task automatic test_directed;
      logic signed [DW-1:0] one, maxv, minv;
      one  = 1 <<< FRAC;
      maxv = {1'b0, {(DW-1){1'b1}}};
      minv = {1'b1, {(DW-1){1'b0}}};
      write_term_count(7'd0);
      send_word(REQ_EVAL, 6'd63, maxv, minv, one, 0);
      write_term_count(7'd1);
      send_word(REQ_EVAL, 6'd0, 0, 0, 0, one);
      write_term_count(7'd2);
      send_word(REQ_LOAD, 6'd0, maxv, maxv, 0, 0);
      send_word(REQ_LOAD, 6'd1, minv, minv, maxv, minv);
      send_word(REQ_EVAL, 6'd0, 0, 0, maxv, maxv);
      send_word(REQ_EVAL, 6'd0, 0, 0, minv, minv);
      send_word(REQ_EVAL, 6'd0, 0, 0, 0, 0);
      send_word(REQ_LOAD, 6'd0, one, 0, 0, 0);
      send_word(REQ_LOAD, 6'd1, 0, -one, 0, 0);
      send_word(REQ_EVAL, 6'd21, maxv, maxv, one, -one);
      send_word(REQ_EVAL, 6'd0, 0, 0, -1, 1);
      write_term_count(7'd64);
      send_word(REQ_LOAD, 6'd63, minv, maxv, 0, 0);
      send_word(REQ_EVAL, 6'd0, 0, 0, one >>> 1, one >>> 2);
      send_word(REQ_EVAL, 6'd0, 0, 0, minv, maxv);
      write_term_count(7'd127);
      send_word(REQ_EVAL, 6'd0, 0, 0, one, one);
      send_word(REQ_EVAL, 6'd0, 0, 0, maxv, 0);
   endtask

   task automatic test_random(input int pct, input int count);
      logic [TC_WIDTH-1:0] tc;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(9))
               0: tc = TC_WIDTH'(64 + $urandom_range(0, 63));
               1: tc = TC_WIDTH'($urandom_range(0, 1));
               default: tc = TC_WIDTH'($urandom_range(2, 10));
            endcase
            write_term_count(tc);
         end
         if ($urandom_range(99) < 55)
            send_word(REQ_LOAD, IDX_WIDTH'($urandom_range(0, NTERMS - 1)), rand_val(15),
                      rand_val(15), $urandom(), $urandom());
         else
            send_word(REQ_EVAL, IDX_WIDTH'($urandom()), $urandom(), $urandom(),
                      rand_val(20), rand_val(20));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         series_value_type exp_v;
         values_seen++;
         if (rsp_overflow) ovf_seen++;
         if (pending_values.size() == 0) begin
            errors++;
            $display("%0t: unexpected word re=%h im=%h ovf=%b", $time,
                     rsp_value_re, rsp_value_im, rsp_overflow);
         end else begin
            exp_v = pending_values.pop_front();
            if (rsp_value_re !== exp_v.value_re) begin
               errors++;
               $display("%0t: value_re expected %h actual %h", $time,
                        exp_v.value_re, rsp_value_re);
            end
            if (rsp_value_im !== exp_v.value_im) begin
               errors++;
               $display("%0t: value_im expected %h actual %h", $time,
                        exp_v.value_im, rsp_value_im);
            end
            if (rsp_overflow !== exp_v.overflow) begin
               errors++;
               $display("%0t: overflow expected %b actual %b", $time,
                        exp_v.overflow, rsp_overflow);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word, result or CSR access
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_psel) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_store();
      test_directed();
      test_random(0, 450);
      test_random(63, 450);
      test_random(19, 450);
      drain();
      repeat (150) @(posedge clock);
      if (pending_values.size() > 0) begin
         errors++;
         $display("%0t: %0d values never arrived", $time, pending_values.size());
      end
      $display("sent %0d words (%0d evaluations), checked %0d values, %0d saturated",
               words_sent, evals_sent, values_seen, ovf_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/chs_pkg.sv
sv/chs_cell.sv
sv/chs_mac.sv
sv/complex_horner_series_eval_core.sv
sim/tb_complex_horner_series_eval_core.sv
